// ----- rtl/flc_pkg.sv -----
// ----------------------------------------------------------------------------
// flc_pkg: shared types and constants for the fault LED blink code block
// Holds the status codes, register indexes, reset values, the state and
// configuration records, and the blink count lookup.
// ----------------------------------------------------------------------------
package flc_pkg;

  // Field widths.
  localparam int StatusW = 4;
  localparam int TickW   = 18;
  localparam int BlinkW  = 4;
  localparam int RegW    = 16;
  localparam int TableW  = 36;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = TableW;

  // System status codes.
  localparam logic [StatusW-1:0] ST_STANDBY    = 4'd0;
  localparam logic [StatusW-1:0] ST_NORMAL     = 4'd1;
  localparam logic [StatusW-1:0] ST_OVERVOLT   = 4'd2;
  localparam logic [StatusW-1:0] ST_UNDERVOLT  = 4'd3;
  localparam logic [StatusW-1:0] ST_OVERCURR   = 4'd4;
  localparam logic [StatusW-1:0] ST_LOST_STEP  = 4'd5;
  localparam logic [StatusW-1:0] ST_SPEED      = 4'd6;
  localparam logic [StatusW-1:0] ST_IMBALANCE  = 4'd7;
  localparam logic [StatusW-1:0] ST_IPM        = 4'd8;
  localparam logic [StatusW-1:0] ST_ADC        = 4'd9;
  localparam logic [StatusW-1:0] ST_TEMP       = 4'd10;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_STANDBY_ON     = 3'd0,
    REG_STANDBY_PERIOD = 3'd1,
    REG_NORMAL_ON      = 3'd2,
    REG_NORMAL_PERIOD  = 3'd3,
    REG_FAULT_HALF     = 3'd4,
    REG_FAULT_GAP      = 3'd5,
    REG_BLINK_TABLE    = 3'd6
  } flc_reg_t;

  // Register reset values.
  localparam logic [RegW-1:0]   RST_STANDBY_ON     = 16'd500;
  localparam logic [RegW-1:0]   RST_STANDBY_PERIOD = 16'd1000;
  localparam logic [RegW-1:0]   RST_NORMAL_ON      = 16'd100;
  localparam logic [RegW-1:0]   RST_NORMAL_PERIOD  = 16'd200;
  localparam logic [RegW-1:0]   RST_FAULT_HALF     = 16'd200;
  localparam logic [RegW-1:0]   RST_FAULT_GAP      = 16'd2000;
  localparam logic [TableW-1:0] RST_BLINK_TABLE    = 36'h987654321;

  typedef struct packed {
    logic [RegW-1:0]   standby_on_ticks;
    logic [RegW-1:0]   standby_period_ticks;
    logic [RegW-1:0]   normal_on_ticks;
    logic [RegW-1:0]   normal_period_ticks;
    logic [RegW-1:0]   fault_half_ticks;
    logic [RegW-1:0]   fault_gap_ticks;
    logic [TableW-1:0] blink_count_table;
  } flc_cfg_t;

  typedef struct packed {
    logic [TickW-1:0]  tick_count;
    logic [BlinkW-1:0] blinks_done;
    logic              led_level;
  } flc_state_t;

  // Blink count of a fault code; zero for codes that are not faults.
  function automatic logic [BlinkW-1:0] blink_count(input logic [TableW-1:0] tbl,
                                                    input logic [StatusW-1:0] status);
    logic [BlinkW-1:0] n;
    unique case (status)
      ST_OVERVOLT:  n = tbl[3:0];
      ST_UNDERVOLT: n = tbl[7:4];
      ST_OVERCURR:  n = tbl[11:8];
      ST_LOST_STEP: n = tbl[15:12];
      ST_SPEED:     n = tbl[19:16];
      ST_IMBALANCE: n = tbl[23:20];
      ST_IPM:       n = tbl[27:24];
      ST_ADC:       n = tbl[31:28];
      ST_TEMP:      n = tbl[35:32];
      default:      n = '0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/flc_if.sv -----
// ----------------------------------------------------------------------------
// flc_if: stream channels of the fault LED blink code block
// One interface for the status tick words and one for the LED level words.
// ----------------------------------------------------------------------------
interface flc_status_if;
  logic                         valid;
  logic                         ready;
  logic [flc_pkg::StatusW-1:0]  status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

interface flc_led_if;
  logic valid;
  logic ready;
  logic led_on;

  modport source (output valid, output led_on, input ready);
  modport sink   (input valid, input led_on, output ready);
endinterface

// ----- rtl/fault_led_blink_code.sv -----
// ----------------------------------------------------------------------------
// fault_led_blink_code: status LED blink code generator
// Timing: the tick word is registered in the input register, and its LED word
// in the output register. Throughput: one tick word per cycle while the output
// is not stalled; the counter update in flc_step is combinational.
// Reset: counters cleared, LED off, registers at their default timing.
// Turns a stream of status ticks into a steady blink or a fault blink code.
// ----------------------------------------------------------------------------
module fault_led_blink_code (
  input  logic                          clk,
  input  logic                          rst,
  flc_status_if.sink                    in_ch,
  flc_led_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [flc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [flc_pkg::CfgDataW-1:0]  cfg_data
);

  flc_pkg::flc_cfg_t           cfg;
  flc_pkg::flc_state_t         state;
  flc_pkg::flc_state_t         state_next;
  logic                        s1_valid;
  logic [flc_pkg::StatusW-1:0] s1_status;
  logic                        out_valid;
  logic                        out_led;
  logic                        s1_adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.standby_on_ticks     <= flc_pkg::RST_STANDBY_ON;
      cfg.standby_period_ticks <= flc_pkg::RST_STANDBY_PERIOD;
      cfg.normal_on_ticks      <= flc_pkg::RST_NORMAL_ON;
      cfg.normal_period_ticks  <= flc_pkg::RST_NORMAL_PERIOD;
      cfg.fault_half_ticks     <= flc_pkg::RST_FAULT_HALF;
      cfg.fault_gap_ticks      <= flc_pkg::RST_FAULT_GAP;
      cfg.blink_count_table    <= flc_pkg::RST_BLINK_TABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flc_pkg::REG_STANDBY_ON:     cfg.standby_on_ticks     <= cfg_data[15:0];
        flc_pkg::REG_STANDBY_PERIOD: cfg.standby_period_ticks <= cfg_data[15:0];
        flc_pkg::REG_NORMAL_ON:      cfg.normal_on_ticks      <= cfg_data[15:0];
        flc_pkg::REG_NORMAL_PERIOD:  cfg.normal_period_ticks  <= cfg_data[15:0];
        flc_pkg::REG_FAULT_HALF:     cfg.fault_half_ticks     <= cfg_data[15:0];
        flc_pkg::REG_FAULT_GAP:      cfg.fault_gap_ticks      <= cfg_data[15:0];
        flc_pkg::REG_BLINK_TABLE:    cfg.blink_count_table    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the output word is free.
  assign s1_adv       = !out_valid || out_ch.ready;
  assign in_ch.ready  = !s1_valid || s1_adv;
  assign out_ch.valid = out_valid;
  assign out_ch.led_on = out_led;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_status <= in_ch.status;
    end
  end

  flc_step u_step (
    .cfg        (cfg),
    .state      (state),
    .status     (s1_status),
    .state_next (state_next)
  );

  // Blink state and output word, updated as a registered tick leaves stage one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_led <= state_next.led_level;
    end
  end

  // Every mode restarts the counter before the top bit is reached.
  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    !state.tick_count[flc_pkg::TickW-1])
    else $error("tick counter reached its top bit");

  // The blink count only moves on a tick that restarts the counter.
  a_blink_restart: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (state.blinks_done != $past(state.blinks_done)))
      |-> (state.tick_count == '0))
    else $error("blink count changed without a counter restart");

  // Input is held back only when both stages are full and the output stalls.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && out_valid && !out_ch.ready))
    else $error("input stalled while the pipeline could move");

  // A registered tick that moves on always yields an output word.
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> out_valid)
    else $error("tick word lost between stages");

endmodule

// ----- rtl/flc_step.sv -----
// ----------------------------------------------------------------------------
// flc_step: next-state logic for one tick
// Advances the tick counter and works out the LED level and blink count
// for the given status, from the current state and the configuration.
// ----------------------------------------------------------------------------
module flc_step (
  input  flc_pkg::flc_cfg_t            cfg,
  input  flc_pkg::flc_state_t          state,
  input  logic [flc_pkg::StatusW-1:0]  status,
  output flc_pkg::flc_state_t          state_next
);

  logic [flc_pkg::TickW-1:0]  tick;
  logic [flc_pkg::TickW-1:0]  on_t;
  logic [flc_pkg::TickW-1:0]  period_t;
  logic [flc_pkg::TickW-1:0]  half_t;
  logic [flc_pkg::TickW-1:0]  full_t;
  logic [flc_pkg::TickW-1:0]  gap_t;
  logic [flc_pkg::BlinkW-1:0] n_blinks;
  logic                       is_fault;
  logic                       is_unknown;

  // Every tick first advances the counter.
  assign tick = state.tick_count + flc_pkg::TickW'(1);

  // Steady blink timing: normal has its own pair, everything else uses standby.
  assign on_t     = (status == flc_pkg::ST_NORMAL)
                    ? flc_pkg::TickW'(cfg.normal_on_ticks)
                    : flc_pkg::TickW'(cfg.standby_on_ticks);
  assign period_t = (status == flc_pkg::ST_NORMAL)
                    ? flc_pkg::TickW'(cfg.normal_period_ticks)
                    : flc_pkg::TickW'(cfg.standby_period_ticks);

  assign half_t   = flc_pkg::TickW'(cfg.fault_half_ticks);
  assign full_t   = {1'b0, cfg.fault_half_ticks, 1'b0};
  assign gap_t    = flc_pkg::TickW'(cfg.fault_gap_ticks);
  assign n_blinks = flc_pkg::blink_count(cfg.blink_count_table, status);

  assign is_fault   = (status >= flc_pkg::ST_OVERVOLT) && (status <= flc_pkg::ST_TEMP);
  assign is_unknown = (status > flc_pkg::ST_TEMP);

  always_comb begin
    state_next            = state;
    state_next.tick_count = tick;
    if (is_fault) begin
      // Fault burst: equal on and off halves per blink, then the dark gap.
      if (state.blinks_done < n_blinks) begin
        priority if (tick <= half_t) begin
          state_next.led_level = 1'b1;
        end else if (tick < full_t) begin
          state_next.led_level = 1'b0;
        end else begin
          state_next.tick_count  = '0;
          state_next.blinks_done = state.blinks_done + flc_pkg::BlinkW'(1);
        end
      end else begin
        state_next.led_level = 1'b0;
        if (tick >= gap_t) begin
          state_next.tick_count  = '0;
          state_next.blinks_done = '0;
        end
      end
    end else begin
      // Steady blink; a restart tick keeps the LED level.
      priority if (tick <= on_t) begin
        state_next.led_level = 1'b1;
      end else if (tick < period_t) begin
        state_next.led_level = 1'b0;
      end else begin
        state_next.tick_count = '0;
        if (is_unknown) begin
          state_next.blinks_done = '0;
        end
      end
    end
  end

endmodule

// ----- dv/flc_led_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_led_checker: LED level predictor and scoreboard for the blink code block
// Watches the tick and LED channels and the register write port. It keeps
// its own copy of the timing registers, the tick counter, the blink count and
// the LED level, and it predicts the LED word of every accepted tick word.
// Each LED word is then compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module flc_led_checker
  import flc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [StatusW-1:0]  in_status,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_led,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  pending,
  output int                  fail_count
);

  // Only the first mismatches are printed; all of them are counted.
  localparam int MaxPrinted = 40;

  flc_cfg_t   timing;
  flc_state_t blinker;
  logic       led_expect_q[$];

  task automatic report_mismatch(input string msg);
    if (fail_count < MaxPrinted) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
    fail_count++;
  endtask

  // One steady blink step: lit up to the on time, dark up to the period, and
  // on reaching the period the counter restarts with the LED left as it was.
  function automatic flc_state_t steady_step(input flc_state_t s,
                                             input logic [RegW-1:0] on_t,
                                             input logic [RegW-1:0] period_t);
    if (s.tick_count <= on_t) begin
      s.led_level = 1'b1;
    end else if (s.tick_count < period_t) begin
      s.led_level = 1'b0;
    end else begin
      s.tick_count = '0;
    end
    return s;
  endfunction

  // State after one tick of the given status.
  function automatic flc_state_t next_blink_state(input flc_state_t s,
                                                  input flc_cfg_t c,
                                                  input logic [StatusW-1:0] status);
    int                shift;
    logic [BlinkW-1:0] burst_len;
    logic [RegW:0]     blink_len;
    s.tick_count = s.tick_count + 1'b1;
    if (status == ST_STANDBY) begin
      s = steady_step(s, c.standby_on_ticks, c.standby_period_ticks);
    end else if (status == ST_NORMAL) begin
      s = steady_step(s, c.normal_on_ticks, c.normal_period_ticks);
    end else if (status <= ST_TEMP) begin
      shift     = (int'(status) - int'(ST_OVERVOLT)) * BlinkW;
      burst_len = c.blink_count_table[shift +: BlinkW];
      blink_len = {c.fault_half_ticks, 1'b0};
      if (s.blinks_done < burst_len) begin
        // Inside the burst: one blink is an on half and an off half.
        if (s.tick_count <= c.fault_half_ticks) begin
          s.led_level = 1'b1;
        end else if (s.tick_count < blink_len) begin
          s.led_level = 1'b0;
        end else begin
          s.tick_count  = '0;
          s.blinks_done = s.blinks_done + 1'b1;
        end
      end else begin
        // Dark gap after the burst; its end restarts the whole code.
        s.led_level = 1'b0;
        if (s.tick_count >= c.fault_gap_ticks) begin
          s.tick_count  = '0;
          s.blinks_done = '0;
        end
      end
    end else begin
      // Unknown codes blink like standby and clear the burst on restart.
      // The counter was just incremented, so zero here means a restart.
      s = steady_step(s, c.standby_on_ticks, c.standby_period_ticks);
      if (s.tick_count == '0) begin
        s.blinks_done = '0;
      end
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      timing.standby_on_ticks     = RST_STANDBY_ON;
      timing.standby_period_ticks = RST_STANDBY_PERIOD;
      timing.normal_on_ticks      = RST_NORMAL_ON;
      timing.normal_period_ticks  = RST_NORMAL_PERIOD;
      timing.fault_half_ticks     = RST_FAULT_HALF;
      timing.fault_gap_ticks      = RST_FAULT_GAP;
      timing.blink_count_table    = RST_BLINK_TABLE;
      blinker = '0;
      led_expect_q.delete();
      pending = 0;
    end else begin
      // Compare each LED word with the oldest prediction.
      if (out_valid && out_ready) begin
        if (led_expect_q.size() == 0) begin
          report_mismatch($sformatf("LED word %0b with no tick word pending", out_led));
        end else if (out_led !== led_expect_q[0]) begin
          report_mismatch($sformatf("led_on expected %0b got %0b", led_expect_q[0], out_led));
          void'(led_expect_q.pop_front());
        end else begin
          void'(led_expect_q.pop_front());
        end
      end

      // Mirror register writes; writes to unused indexes are dropped.
      if (cfg_we) begin
        case (cfg_index)
          REG_STANDBY_ON:     timing.standby_on_ticks     = cfg_data[RegW-1:0];
          REG_STANDBY_PERIOD: timing.standby_period_ticks = cfg_data[RegW-1:0];
          REG_NORMAL_ON:      timing.normal_on_ticks      = cfg_data[RegW-1:0];
          REG_NORMAL_PERIOD:  timing.normal_period_ticks  = cfg_data[RegW-1:0];
          REG_FAULT_HALF:     timing.fault_half_ticks     = cfg_data[RegW-1:0];
          REG_FAULT_GAP:      timing.fault_gap_ticks      = cfg_data[RegW-1:0];
          REG_BLINK_TABLE:    timing.blink_count_table    = cfg_data[TableW-1:0];
          default: ;
        endcase
      end

      // Predict the LED word of each accepted tick word.
      if (in_valid && in_ready) begin
        blinker = next_blink_state(blinker, timing, in_status);
        led_expect_q.push_back(blinker.led_level);
      end
      pending = led_expect_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the fault LED blink code generator
// Drives status tick words and random backpressure into the block, loads
// the timing registers between phases, and leaves all prediction and
// comparison to the checker. A short directed sequence walks every status
// code, then random runs of repeated codes exercise bursts, gaps and restarts
// under a range of register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import flc_pkg::*;

  localparam int        TimeoutNs   = 5_000_000;
  localparam int        NumPhases   = 12;
  localparam int        PhaseTicks  = 150;
  localparam int        HoldOffLen  = 150;
  localparam int        SettleTicks = 10;
  localparam int        IdlePct     = 81;
  localparam int        BothIdlePct = 19;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  // Idle patterns, one per phase in rotation.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  pending;
  int                  fail_count;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  recv_hold;

  flc_status_if in_if ();
  flc_led_if    out_if ();

  fault_led_blink_code dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  flc_led_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_status  (in_if.status),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_led    (out_if.led_on),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold > 0) begin
        out_if.ready <= 1'b0;
        recv_hold = recv_hold - 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Overall time limit.
  initial begin
    #(TimeoutNs);
    $display("Test completed with failures");
    $finish;
  end

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;           recv_stall_pct = 0;           end
      IDLE_SENDER:   begin send_idle_pct = IdlePct;     recv_stall_pct = 0;           end
      IDLE_RECEIVER: begin send_idle_pct = 0;           recv_stall_pct = IdlePct;     end
      default:       begin send_idle_pct = BothIdlePct; recv_stall_pct = BothIdlePct; end
    endcase
  endtask

  // Offer one tick word, after a random idle stretch, and wait for its
  // acceptance. Valid stays high so the next word can follow at once.
  task automatic send_tick(input logic [StatusW-1:0] status);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.status <= status;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every LED word has come back.
  task automatic wait_led_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Load every register. The 16-bit ones get random upper bits, which the
  // block must drop; a write to an unused index follows and must be ignored.
  task automatic load_timing(input logic [RegW-1:0] sb_on, input logic [RegW-1:0] sb_period,
                             input logic [RegW-1:0] nm_on, input logic [RegW-1:0] nm_period,
                             input logic [RegW-1:0] half, input logic [RegW-1:0] gap,
                             input logic [TableW-1:0] counts);
    write_reg(REG_STANDBY_ON,     {20'($urandom), sb_on});
    write_reg(REG_STANDBY_PERIOD, {20'($urandom), sb_period});
    write_reg(REG_NORMAL_ON,      {20'($urandom), nm_on});
    write_reg(REG_NORMAL_PERIOD,  {20'($urandom), nm_period});
    write_reg(REG_FAULT_HALF,     {20'($urandom), half});
    write_reg(REG_FAULT_GAP,      {20'($urandom), gap});
    write_reg(REG_BLINK_TABLE,    counts);
    write_reg(REG_UNUSED,         {4'($urandom), 32'($urandom)});
  endtask

  // Mostly fault codes, so bursts and gaps get reached; some steady codes
  // and some unknown codes mixed in.
  function automatic logic [StatusW-1:0] pick_status();
    int r;
    r = $urandom_range(99);
    if (r < 65) return StatusW'($urandom_range(ST_OVERVOLT, ST_TEMP));
    else if (r < 90) return StatusW'($urandom_range(ST_STANDBY, ST_NORMAL));
    else return StatusW'($urandom_range(ST_TEMP + 1, 15));
  endfunction

  initial begin
    logic [StatusW-1:0] directed_seq[$];
    logic [StatusW-1:0] status;
    int                 sent;
    int                 run_len;

    rst          <= 1'b1;
    in_if.valid  <= 1'b0;
    in_if.status <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    recv_hold    = 0;
    set_idle_mode(IDLE_NONE);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one word at the reset timing, then short timing so that
    // blinks, a burst, a gap and a zero-length burst show within a few words.
    send_tick(ST_TEMP);
    wait_led_drained();
    load_timing(16'd2, 16'd4, 16'd1, 16'd3, 16'd1, 16'd3, 36'h1_2345_6F02);
    directed_seq = '{ST_STANDBY, ST_STANDBY, ST_NORMAL, ST_NORMAL,
                     ST_OVERVOLT, ST_OVERVOLT, ST_OVERVOLT, ST_OVERVOLT,
                     ST_OVERVOLT, ST_OVERVOLT, ST_OVERVOLT, ST_OVERVOLT,
                     ST_UNDERVOLT, ST_UNDERVOLT, ST_OVERCURR, ST_LOST_STEP,
                     ST_SPEED, ST_IMBALANCE, ST_IPM, ST_ADC, ST_TEMP,
                     4'd11, 4'd15, 4'd15};
    foreach (directed_seq[i]) send_tick(directed_seq[i]);
    wait_led_drained();

    // Random phases, each with its own timing and idle pattern.
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_led_drained();
      set_idle_mode(idle_mode_t'(phase % 4));
      if (phase == 3) begin
        load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    36'hF_FFFF_FFFF);
      end else if (phase == 7) begin
        load_timing('0, '0, '0, '0, '0, '0, '0);
      end else begin
        load_timing(RegW'($urandom_range(0, 6)), RegW'($urandom_range(0, 10)),
                    RegW'($urandom_range(0, 6)), RegW'($urandom_range(0, 10)),
                    RegW'($urandom_range(0, 4)), RegW'($urandom_range(0, 12)),
                    {4'($urandom), 32'($urandom)});
      end
      sent = 0;
      while (sent < PhaseTicks) begin
        status  = pick_status();
        run_len = $urandom_range(1, 30);
        for (int k = 0; k < run_len && sent < PhaseTicks; k++) begin
          // Long receiver hold-off while words keep coming, so the block fills.
          if (phase == 0 && sent == 60) recv_hold = HoldOffLen;
          // Sender pause until every LED word is back, mid-phase.
          if (phase == 5 && sent == 75) wait_led_drained();
          send_tick(status);
          sent++;
        end
      end
    end

    wait_led_drained();
    repeat (SettleTicks) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/flc_pkg.sv
rtl/flc_if.sv
rtl/flc_step.sv
rtl/fault_led_blink_code.sv
dv/flc_led_checker.sv
dv/tb_top.sv
